// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SFCD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SFCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/sfcd_pkg.sv -----
// Types and constants of the SBUS frame channel decoder.
package sfcd_pkg;

	localparam int FRAME_LEN = 25;
	localparam int NUM_CH = 16;
	localparam int RAW_W = 11;
	localparam int CH_BITS = NUM_CH * RAW_W;
	localparam int CFG_DW = 16;
	localparam int CFG_IW = 2;
	localparam int JOBQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 2;
	localparam int DVD_W = 28;
	localparam int DIV_STEPS = DVD_W / 2;

	localparam logic [7:0] HEADER_BYTE = 8'h0F;
	localparam logic [7:0] FOOTER_BYTE = 8'h00;

	localparam logic [10:0] IN_MIN_RST = 11'd172;
	localparam logic [10:0] IN_MAX_RST = 11'd1811;
	localparam logic [15:0] OUT_MIN_RST = 16'd1000;
	localparam logic [15:0] OUT_MAX_RST = 16'd2000;

	typedef enum logic [CFG_IW-1:0] {
		REG_IN_MIN = 2'd0,
		REG_IN_MAX = 2'd1,
		REG_OUT_MIN = 2'd2,
		REG_OUT_MAX = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic frame_start;
	} frame_beat_t;

	typedef struct packed {
		logic [3:0] channel_index;
		logic [15:0] channel_value;
		logic [10:0] raw_channel;
		logic [7:0] status_flags;
		logic last_channel;
	} chan_beat_t;

	typedef struct packed {
		logic [7:0] flags;
		logic [CH_BITS-1:0] data;
	} job_t;

	typedef struct packed {
		logic [10:0] in_min;
		logic [10:0] in_max;
		logic [15:0] out_min;
		logic [15:0] out_max;
	} cfg_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CALC,
		B_DIV,
		B_FIX,
		B_EMIT
	} back_state_t;

endpackage

// ----- design/sfcd_fifo.sv -----
// Small first-word-fall-through queue.
module sfcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] wdata,
	output logic full,
	input logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- design/sfcd_front.sv -----
// Front end: collects frame bytes, checks header and footer, queues good frames.
module sfcd_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sfcd_pkg::frame_beat_t frame,
	output logic full,
	input logic job_full,
	output logic job_push,
	output sfcd_pkg::job_t job
);

	localparam logic [4:0] FRAME_END = 5'(sfcd_pkg::FRAME_LEN);
	localparam logic [4:0] LAST_POS = 5'(sfcd_pkg::FRAME_LEN - 1);

	logic [7:0] store_q [0:sfcd_pkg::FRAME_LEN-2];
	logic [4:0] pos_q;
	logic accept;
	logic in_frame;
	logic frame_done;

	assign full = job_full;
	assign accept = push & ~full;
	assign in_frame = accept & ~frame.frame_start & (pos_q < FRAME_END);
	assign frame_done = in_frame & (pos_q == LAST_POS);
	assign job_push = frame_done & (store_q[0] == sfcd_pkg::HEADER_BYTE)
		& (frame.frame_byte == sfcd_pkg::FOOTER_BYTE);

	always_comb begin
		job.flags = store_q[sfcd_pkg::FRAME_LEN-2];
		for (int i = 0; i < sfcd_pkg::CH_BITS / 8; i++) begin
			job.data[8*i +: 8] = store_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= FRAME_END;
		end else if (accept && frame.frame_start) begin
			pos_q <= 5'd1;
		end else if (in_frame) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame.frame_start) begin
			store_q[0] <= frame.frame_byte;
		end else if (in_frame && pos_q < LAST_POS) begin
			store_q[pos_q] <= frame.frame_byte;
		end
	end

endmodule

// ----- design/sfcd_back.sv -----
// Back end: unpacks channels, clamps and scales them through a shared divider.
module sfcd_back #(
	parameter int OUT_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input sfcd_pkg::cfg_t cfg,
	input logic job_empty,
	input sfcd_pkg::job_t job,
	output logic job_pop,
	input logic res_full,
	output logic res_push,
	output sfcd_pkg::chan_beat_t res
);

	localparam logic [15:0] VAL_MASK = 16'((32'd1 << OUT_WIDTH) - 32'd1);
	localparam logic [3:0] LAST_CH = 4'(sfcd_pkg::NUM_CH - 1);
	localparam logic [3:0] LAST_STEP = 4'(sfcd_pkg::DIV_STEPS - 1);
	localparam int DW = sfcd_pkg::DVD_W;

	sfcd_pkg::back_state_t state_q, state_d;

	logic [sfcd_pkg::CH_BITS-1:0] data_q;
	logic [7:0] flags_q;
	logic [3:0] ch_q;
	logic [10:0] raw_q;
	logic [15:0] val_q;
	logic [DW-1:0] dvd_q;
	logic [10:0] rem_q;
	logic [10:0] den_q;
	logic neg_q;
	logic [3:0] step_q;

	logic [10:0] raw_c;
	logic lt_c;
	logic gt_c;
	logic [10:0] den_c;
	logic [10:0] diff_c;
	logic [16:0] dout_c;
	logic [15:0] mag_c;
	logic [26:0] prod_c;
	logic clamp_c;
	logic [10:0] rem_a, rem_b;
	logic [DW-1:0] dvd_a, dvd_b;
	logic [15:0] qlo_c;

	assign raw_c = data_q[sfcd_pkg::RAW_W-1:0];
	assign lt_c = raw_c < cfg.in_min;
	assign gt_c = raw_c > cfg.in_max;
	assign den_c = cfg.in_max - cfg.in_min;
	assign diff_c = raw_c - cfg.in_min;
	assign dout_c = {1'b0, cfg.out_max} - {1'b0, cfg.out_min};
	assign mag_c = dout_c[16] ? 16'(17'd0 - dout_c) : dout_c[15:0];
	assign prod_c = {11'd0, mag_c} * {16'd0, diff_c};
	assign clamp_c = lt_c | gt_c | (den_c == 11'd0);
	assign qlo_c = dvd_q[15:0];

	// two restoring divide steps per cycle
	always_comb begin
		logic [11:0] r1;
		logic [11:0] r2;
		logic ge1;
		logic ge2;
		r1 = {rem_q, dvd_q[DW-1]};
		ge1 = r1 >= {1'b0, den_q};
		rem_a = ge1 ? 11'(r1 - {1'b0, den_q}) : r1[10:0];
		dvd_a = {dvd_q[DW-2:0], ge1};
		r2 = {rem_a, dvd_a[DW-1]};
		ge2 = r2 >= {1'b0, den_q};
		rem_b = ge2 ? 11'(r2 - {1'b0, den_q}) : r2[10:0];
		dvd_b = {dvd_a[DW-2:0], ge2};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sfcd_pkg::B_IDLE: begin
				if (!job_empty) begin
					state_d = sfcd_pkg::B_CALC;
				end
			end
			sfcd_pkg::B_CALC: begin
				state_d = clamp_c ? sfcd_pkg::B_EMIT : sfcd_pkg::B_DIV;
			end
			sfcd_pkg::B_DIV: begin
				if (step_q == LAST_STEP) begin
					state_d = sfcd_pkg::B_FIX;
				end
			end
			sfcd_pkg::B_FIX: begin
				state_d = sfcd_pkg::B_EMIT;
			end
			sfcd_pkg::B_EMIT: begin
				if (!res_full) begin
					state_d = (ch_q == LAST_CH) ? sfcd_pkg::B_IDLE : sfcd_pkg::B_CALC;
				end
			end
			default: begin
				state_d = sfcd_pkg::B_IDLE;
			end
		endcase
	end

	always_comb begin
		job_pop = (state_q == sfcd_pkg::B_IDLE) & ~job_empty;
		res_push = (state_q == sfcd_pkg::B_EMIT) & ~res_full;
		res.channel_index = ch_q;
		res.channel_value = val_q;
		res.raw_channel = raw_q;
		res.status_flags = flags_q;
		res.last_channel = (ch_q == LAST_CH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfcd_pkg::B_IDLE;
			ch_q <= '0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (job_pop) begin
				ch_q <= '0;
			end else if (res_push) begin
				ch_q <= ch_q + 1'b1;
			end
			if (state_q == sfcd_pkg::B_CALC) begin
				step_q <= '0;
			end else if (state_q == sfcd_pkg::B_DIV) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			data_q <= job.data;
			flags_q <= job.flags;
		end else if (res_push) begin
			data_q <= data_q >> sfcd_pkg::RAW_W;
		end
		case (state_q)
			sfcd_pkg::B_CALC: begin
				raw_q <= raw_c;
				den_q <= den_c;
				neg_q <= dout_c[16];
				rem_q <= '0;
				dvd_q <= {1'b0, prod_c};
				if (lt_c) begin
					val_q <= cfg.out_min & VAL_MASK;
				end else if (gt_c) begin
					val_q <= cfg.out_max & VAL_MASK;
				end else begin
					val_q <= cfg.out_min & VAL_MASK;
				end
			end
			sfcd_pkg::B_DIV: begin
				rem_q <= rem_b;
				dvd_q <= dvd_b;
			end
			sfcd_pkg::B_FIX: begin
				val_q <= (cfg.out_min + (neg_q ? 16'(17'd0 - {1'b0, qlo_c}) : qlo_c))
					& VAL_MASK;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- design/sbus_frame_channel_decoder_top.sv -----
// Top level of the SBUS frame channel decoder.
//
// Input channel: one frame byte per beat (push/full). A beat with frame_start
// set restarts the frame; bytes outside a frame are dropped. Bytes are taken
// one per cycle while the frame queue (two frames) has room.
// On the 25th byte the frame is checked: header 0x0F, footer 0x00. A good
// frame yields 16 result beats (empty/pop), channel 0 first, the last one
// marked with last_channel; a bad frame yields nothing.
// Per channel: setup, then, unless the value is clamped or the input range has
// zero width, the shared divider at two quotient bits per cycle and a fix-up;
// last the hand-off, which waits while the result queue is full. The back end
// takes one frame, then works through its 16 channels one after another before
// it takes the next frame.
// A stalled receiver fills the two-entry result queue and holds the back end;
// the front keeps taking bytes until a second complete frame is queued.
// Registers (wr_en/wr_index/wr_data) must be written only while idle; the block does not enforce it.
// Reset: registers return to their defaults, all queues empty, and the block
// waits for a frame start.
`include "assert_macros.svh"

module sbus_frame_channel_decoder_top #(
	parameter int OUT_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sfcd_pkg::frame_beat_t frame,
	output logic full,
	output logic empty,
	input logic pop,
	output sfcd_pkg::chan_beat_t chan,
	input logic wr_en,
	input logic [sfcd_pkg::CFG_IW-1:0] wr_index,
	input logic [sfcd_pkg::CFG_DW-1:0] wr_data
);

	sfcd_pkg::cfg_t cfg_q;
	sfcd_pkg::job_t job_in;
	sfcd_pkg::job_t job_out;
	sfcd_pkg::chan_beat_t res;
	logic job_push;
	logic job_full;
	logic job_pop;
	logic job_empty;
	logic res_push;
	logic res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_min <= sfcd_pkg::IN_MIN_RST;
			cfg_q.in_max <= sfcd_pkg::IN_MAX_RST;
			cfg_q.out_min <= sfcd_pkg::OUT_MIN_RST;
			cfg_q.out_max <= sfcd_pkg::OUT_MAX_RST;
		end else if (wr_en) begin
			case (sfcd_pkg::reg_idx_t'(wr_index))
				sfcd_pkg::REG_IN_MIN: cfg_q.in_min <= wr_data[10:0];
				sfcd_pkg::REG_IN_MAX: cfg_q.in_max <= wr_data[10:0];
				sfcd_pkg::REG_OUT_MIN: cfg_q.out_min <= wr_data;
				sfcd_pkg::REG_OUT_MAX: cfg_q.out_max <= wr_data;
				default: begin
				end
			endcase
		end
	end

	sfcd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.frame(frame),
		.full(full),
		.job_full(job_full),
		.job_push(job_push),
		.job(job_in)
	);

	sfcd_fifo #(
		.WIDTH($bits(sfcd_pkg::job_t)),
		.DEPTH(sfcd_pkg::JOBQ_DEPTH)
	) u_jobq (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.wdata(job_in),
		.full(job_full),
		.pop(job_pop),
		.rdata(job_out),
		.empty(job_empty)
	);

	sfcd_back #(
		.OUT_WIDTH(OUT_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.job_empty(job_empty),
		.job(job_out),
		.job_pop(job_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res)
	);

	sfcd_fifo #(
		.WIDTH($bits(sfcd_pkg::chan_beat_t)),
		.DEPTH(sfcd_pkg::RESQ_DEPTH)
	) u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res),
		.full(res_full),
		.pop(pop),
		.rdata(chan),
		.empty(empty)
	);

	`SFCD_ASSERT_ALWAYS(a_job_no_overflow, clk, !(job_push && job_full), "frame queue overflow")
	`SFCD_ASSERT_ALWAYS(a_res_no_overflow, clk, !(res_push && res_full), "result queue overflow")
	`SFCD_ASSERT_RST(a_last_marks_ch15, clk, arst_n, (!empty |-> (chan.last_channel == (chan.channel_index == 4'(sfcd_pkg::NUM_CH - 1)))), "last beat mark mismatch")
	`SFCD_ASSERT_RST(a_pop_only_idle, clk, arst_n, (job_pop |=> !job_pop), "back end took two frames in a row")

endmodule

// ----- tb/sfcd_chan_checker.sv -----
// Checker for the SBUS frame channel decoder: mirrors frames and registers, predicts and compares channel beats.
module sfcd_chan_checker
	import sfcd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input frame_beat_t frame,
	input logic full,
	input logic empty,
	input logic pop,
	input chan_beat_t chan,
	input logic wr_en,
	input logic [CFG_IW-1:0] wr_index,
	input logic [CFG_DW-1:0] wr_data,
	output int fail_count,
	output int pending,
	output int beats_checked,
	output int frames_decoded
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] frame_mem [FRAME_LEN];
	int byte_pos;
	cfg_t ranges;
	chan_beat_t chan_exp_q [$];
	int errors = 0;
	int n_checked = 0;
	int n_frames = 0;

	function automatic logic [15:0] scale_raw(input logic [10:0] raw);
		longint span_in;
		longint prod;
		longint q;
		if (raw < ranges.in_min)
			return ranges.out_min;
		if (raw > ranges.in_max)
			return ranges.out_max;
		span_in = longint'(ranges.in_max) - longint'(ranges.in_min);
		if (span_in == 0)
			return ranges.out_min;
		prod = (longint'(raw) - longint'(ranges.in_min)) *
			(longint'(ranges.out_max) - longint'(ranges.out_min));
		q = prod / span_in + longint'(ranges.out_min);
		return q[15:0];
	endfunction

	function automatic void decode_frame();
		logic [FRAME_LEN*8-1:0] fv;
		chan_beat_t beat;
		int i;
		int k;
		for (i = 0; i < FRAME_LEN; i++)
			fv[8*i +: 8] = frame_mem[i];
		for (k = 0; k < NUM_CH; k++) begin
			beat.channel_index = 4'(k);
			beat.raw_channel = fv[8 + RAW_W*k +: RAW_W];
			beat.channel_value = scale_raw(beat.raw_channel);
			beat.status_flags = frame_mem[23];
			beat.last_channel = (k == NUM_CH - 1);
			chan_exp_q.push_back(beat);
		end
		n_frames++;
	endfunction

	function automatic void take_byte(input frame_beat_t fb);
		if (fb.frame_start) begin
			frame_mem[0] = fb.frame_byte;
			byte_pos = 1;
		end else if (byte_pos < FRAME_LEN) begin
			frame_mem[byte_pos] = fb.frame_byte;
			byte_pos++;
			if (byte_pos == FRAME_LEN && frame_mem[0] == HEADER_BYTE &&
				frame_mem[FRAME_LEN-1] == FOOTER_BYTE)
				decode_frame();
		end
	endfunction

	function automatic void cmp_field(input string fname, input logic [31:0] want, got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			errors++;
		end
	endfunction

	function automatic void check_beat();
		chan_beat_t want;
		if (chan_exp_q.size() == 0) begin
			$error("channel beat with none expected: index %0d raw %0d",
				chan.channel_index, chan.raw_channel);
			errors++;
			return;
		end
		want = chan_exp_q.pop_front();
		n_checked++;
		cmp_field("channel_index", want.channel_index, chan.channel_index);
		cmp_field("channel_value", want.channel_value, chan.channel_value);
		cmp_field("raw_channel", want.raw_channel, chan.raw_channel);
		cmp_field("status_flags", want.status_flags, chan.status_flags);
		cmp_field("last_channel", want.last_channel, chan.last_channel);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos = FRAME_LEN;
			ranges = '{in_min: IN_MIN_RST, in_max: IN_MAX_RST,
				out_min: OUT_MIN_RST, out_max: OUT_MAX_RST};
			chan_exp_q.delete();
			pending <= 0;
			fail_count <= errors;
			beats_checked <= n_checked;
			frames_decoded <= n_frames;
		end else begin
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_IN_MIN: ranges.in_min = wr_data[RAW_W-1:0];
					REG_IN_MAX: ranges.in_max = wr_data[RAW_W-1:0];
					REG_OUT_MIN: ranges.out_min = wr_data;
					REG_OUT_MAX: ranges.out_max = wr_data;
					default: ;
				endcase
			end
			if (pop && !empty)
				check_beat();
			if (push && !full)
				take_byte(frame);
			pending <= chan_exp_q.size();
			fail_count <= errors;
			beats_checked <= n_checked;
			frames_decoded <= n_frames;
		end
	end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the SBUS frame channel decoder: clock, reset, byte and pop traffic, verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfcd_pkg::*;

	localparam int SETTLE = 300;
	localparam int RX_HOLD = 600;
	localparam int LIMIT = 300000;

	typedef logic [FRAME_LEN*8-1:0] frame_vec_t;

	logic clk;
	logic arst_n;
	logic push;
	frame_beat_t frame;
	logic full;
	logic empty;
	logic pop;
	chan_beat_t chan;
	logic wr_en;
	logic [CFG_IW-1:0] wr_index;
	logic [CFG_DW-1:0] wr_data;

	int fail_count;
	int pending;
	int beats_checked;
	int frames_decoded;

	int bytes_sent = 0;
	int stray_bytes = 0;
	int n_settings = 0;
	int cycle_count = 0;
	bit quiet = 0;
	bit rx_hold_req = 0;
	logic [10:0] cur_in_min = IN_MIN_RST;
	logic [10:0] cur_in_max = IN_MAX_RST;

	sbus_frame_channel_decoder_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.frame(frame),
		.full(full),
		.empty(empty),
		.pop(pop),
		.chan(chan),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	sfcd_chan_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.frame(frame),
		.full(full),
		.empty(empty),
		.pop(pop),
		.chan(chan),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.fail_count(fail_count),
		.pending(pending),
		.beats_checked(beats_checked),
		.frames_decoded(frames_decoded)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles, %0d beats still expected", cycle_count, pending);
		$display("Regression FAIL");
		$finish;
	end

	// receiver: random stall bursts, one long hold on request, steady in the last part
	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 0;
				pop <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic s);
		frame <= '{frame_byte: b, frame_start: s};
		push <= 1'b1;
		do @(posedge clk); while (full);
		bytes_sent++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic put_stray(input logic [7:0] b);
		put_byte(b, 1'b0);
		stray_bytes++;
	endtask

	task automatic send_frame(input frame_vec_t fv, input int n);
		int i;
		for (i = 0; i < n; i++)
			put_byte(fv[8*i +: 8], i == 0);
	endtask

	task automatic drain_and_settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] v);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		@(posedge clk);
	endtask

	task automatic set_ranges(input logic [10:0] i_lo, i_hi, input logic [15:0] o_lo, o_hi);
		drain_and_settle();
		put_reg(REG_IN_MIN, {5'($urandom), i_lo});
		put_reg(REG_IN_MAX, {5'($urandom), i_hi});
		put_reg(REG_OUT_MIN, o_lo);
		put_reg(REG_OUT_MAX, o_hi);
		wr_en <= 1'b0;
		cur_in_min = i_lo;
		cur_in_max = i_hi;
		n_settings++;
	endtask

	function automatic logic [10:0] pick_raw(input int sel);
		case (sel)
			0: return cur_in_min;
			1: return cur_in_max;
			2: return cur_in_min - 11'd1;
			3: return cur_in_max + 11'd1;
			4: return 11'd0;
			5: return 11'h7FF;
			default: return 11'($urandom);
		endcase
	endfunction

	// good: header and footer right; otherwise one or both corrupted
	function automatic frame_vec_t make_frame(input bit good);
		logic [CH_BITS-1:0] chans;
		logic [7:0] hdr;
		logic [7:0] ftr;
		int k;
		int sel;
		for (k = 0; k < NUM_CH; k++)
			chans[RAW_W*k +: RAW_W] = pick_raw($urandom_range(0, 9));
		hdr = HEADER_BYTE;
		ftr = FOOTER_BYTE;
		if (!good) begin
			sel = $urandom_range(0, 2);
			if (sel != 1) begin
				hdr = 8'($urandom);
				if (hdr == HEADER_BYTE)
					hdr = ~hdr;
			end
			if (sel != 0)
				ftr = 8'($urandom_range(1, 255));
		end
		return {ftr, 8'($urandom), chans, hdr};
	endfunction

	function automatic frame_vec_t edge_frame(input logic [7:0] flags);
		logic [CH_BITS-1:0] chans;
		int k;
		for (k = 0; k < NUM_CH; k++)
			chans[RAW_W*k +: RAW_W] = pick_raw(k % 6);
		return {FOOTER_BYTE, flags, chans, HEADER_BYTE};
	endfunction

	task automatic random_traffic(input int n_bytes);
		int stop;
		stop = bytes_sent - stray_bytes + n_bytes;
		while (bytes_sent - stray_bytes < stop) begin
			case ($urandom_range(0, 9))
				0: send_frame(make_frame(0), FRAME_LEN);
				1: send_frame(make_frame(1), $urandom_range(1, FRAME_LEN - 1));
				2: repeat ($urandom_range(1, 4)) put_stray(8'($urandom));
				default: send_frame(make_frame(1), FRAME_LEN);
			endcase
		end
	endtask

	initial begin
		frame_vec_t fv;
		arst_n <= 1'b0;
		push <= 1'b0;
		frame <= '0;
		wr_en <= 1'b0;
		wr_index <= REG_IN_MIN;
		wr_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bytes before any start, extremes, restart, bad frames, edge raws
		put_stray(HEADER_BYTE);
		put_stray(8'hFF);
		send_frame({FOOTER_BYTE, 8'hFF, {CH_BITS{1'b1}}, HEADER_BYTE}, FRAME_LEN);
		send_frame({FOOTER_BYTE, 8'h00, {CH_BITS{1'b0}}, HEADER_BYTE}, FRAME_LEN);
		fv = make_frame(1);
		send_frame(fv, 12);
		send_frame(edge_frame(8'h0C), FRAME_LEN);
		fv = make_frame(1);
		fv[7:0] = 8'hF0;
		send_frame(fv, FRAME_LEN);
		fv = make_frame(1);
		fv[FRAME_LEN*8-1 -: 8] = 8'h80;
		send_frame(fv, FRAME_LEN);
		put_stray(8'h55);
		put_stray(8'hAA);

		set_ranges(11'd0, 11'h7FF, 16'd0, 16'hFFFF);
		send_frame(edge_frame(8'h03), FRAME_LEN);
		random_traffic(10);

		// zero-width input range
		set_ranges(11'd1024, 11'd1024, 16'd500, 16'd600);
		send_frame(edge_frame(8'h08), FRAME_LEN);

		// inverted input range
		set_ranges(11'd1500, 11'd300, 16'd7, 16'd9);
		random_traffic(15);

		// inverted output range, with the receiver held off while frames pile up
		set_ranges(IN_MIN_RST, IN_MAX_RST, 16'hFFFF, 16'd0);
		rx_hold_req = 1;
		repeat (3) send_frame(make_frame(1), FRAME_LEN);
		random_traffic(1);

		set_ranges(11'h7FF, 11'h7FF, 16'hFFFF, 16'hFFFF);
		send_frame(edge_frame(8'hF0), FRAME_LEN);

		repeat (2) begin
			set_ranges(11'($urandom), 11'($urandom), 16'($urandom), 16'($urandom));
			random_traffic(10);
		end

		quiet = 1;
		set_ranges(IN_MIN_RST, IN_MAX_RST, OUT_MIN_RST, OUT_MAX_RST);
		random_traffic(25);
		drain_and_settle();

		$display("Summary: %0d bytes sent (%0d outside frames), %0d good frames, %0d beats checked",
			bytes_sent, stray_bytes, frames_decoded, beats_checked);
		$display("Summary: %0d range settings incl. full, zero-width, inverted; long output hold",
			n_settings);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/sfcd_pkg.sv
design/sfcd_fifo.sv
design/sfcd_front.sv
design/sfcd_back.sv
design/sbus_frame_channel_decoder_top.sv
tb/sfcd_chan_checker.sv
tb/tb.sv
